[hdl/prwm_pkg.sv]
// Package for the pulse rate window meter: field widths, register map,
// reset values and the sequencer state type.
// No dependencies; imported by prwm_div and pulse_rate_window_meter.
package prwm_pkg;

   // Field and datapath widths
   localparam int WINDOW_W    = 16;
   localparam int SCALE_W     = 8;
   localparam int THRESH_W    = 7;
   localparam int BEATS_W     = 8;
   localparam int RATE_W      = 16;
   localparam int CHANGE_W    = 24;
   localparam int SLOT_W      = 3;
   localparam int DIFF_W      = RATE_W + 1;
   localparam int DIVIDEND_W  = 23;
   localparam int DIVISOR_W   = RATE_W;
   localparam int STEP_W      = $clog2(DIVIDEND_W);

   // Ring depth default
   localparam int RING_SLOTS_DEFAULT = 8;

   // Arithmetic constants
   localparam int PCT_FACTOR = 100;
   localparam logic [BEATS_W-1:0]  MAX_BEATS = 8'd255;
   localparam logic [WINDOW_W-1:0] MAX_TICKS = 16'hFFFF;

   // Register map
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_WINDOW_TICKS = 2'd0;
   localparam logic [1:0] REG_RATE_SCALE   = 2'd1;
   localparam logic [1:0] REG_THRESHOLD    = 2'd2;

   // Register reset values
   localparam logic [WINDOW_W-1:0] WINDOW_TICKS_RESET = 16'd100;
   localparam logic [SCALE_W-1:0]  RATE_SCALE_RESET   = 8'd20;
   localparam logic [THRESH_W-1:0] THRESHOLD_RESET    = 7'd15;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

endpackage

[hdl/prwm_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on prwm_pkg for operand widths.
module prwm_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [prwm_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [prwm_pkg::DIVISOR_W-1:0]    divisor,
   output logic [prwm_pkg::DIVIDEND_W-1:0]   quotient,
   output logic                              done
);
   import prwm_pkg::*;

   logic                    busy_ff,  busy_in;
   logic                    done_ff,  done_in;
   logic [STEP_W-1:0]       count_ff, count_in;
   logic [DIVISOR_W-1:0]    rem_ff,   rem_in;
   logic [DIVIDEND_W-1:0]   quo_ff,   quo_in;
   logic [DIVISOR_W-1:0]    dsr_ff,   dsr_in;

   logic [DIVISOR_W:0]      partial;
   logic [DIVISOR_W:0]      trial;
   logic                    fits;

   // Trial subtract of the divisor from the shifted partial remainder
   always_comb begin
      partial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      trial   = partial - {1'b0, dsr_ff};
      fits    = ~trial[DIVISOR_W];
   end

   // Step control and datapath
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = STEP_W'(DIVIDEND_W - 1);
         rem_in   = '0;
         quo_in   = dividend;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? trial[DIVISOR_W-1:0] : partial[DIVISOR_W-1:0];
         quo_in   = {quo_ff[DIVIDEND_W-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dsr_ff   <= dsr_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

[hdl/pulse_rate_window_meter.sv]
// Pulse rate window meter: beat counting, rate scaling, percent change
// against a ring of stored rates. Depends on prwm_pkg and prwm_div.
//
// Usage: one req_ word is one sample of the pulse line (req_beat_level)
// with a flag for an elapsed time tick (req_tick). Rising edges are counted
// over window_ticks ticks; a line high at window open counts as a beat and
// the count stops at 255. On the closing tick the count is scaled by
// rate_scale and compared with the rate in the current ring slot. One rsp_
// word per closed window carries the rate, the signed percent change, the
// store flag and the slot; samples that do not close a window give none.
// A sample that does not close a window leaves the sequencer idle,
// so such samples are taken on back-to-back cycles. A closing sample
// passes through fetch, 23 divider steps, divider done and finish, or
// through fetch and finish alone when the stored rate is zero; req_ready
// is low meanwhile.
// A result waits in the output register while rsp_ready is low; samples are
// still taken then, but the next closing sample holds in the finish step
// until that register frees. Reset clears counters, the slot pointer, the
// output valid and all ring valid flags, and restores the register values.
// Registers sit at byte addresses 0, 4 and 8 of the csr_ port.
module pulse_rate_window_meter #(
   parameter int RING_SLOTS = prwm_pkg::RING_SLOTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // sample channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_beat_level,
   input  logic                              req_tick,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [prwm_pkg::RATE_W-1:0]       rsp_rate_bpm,
   output logic signed [prwm_pkg::CHANGE_W-1:0] rsp_change_pct,
   output logic                              rsp_stored,
   output logic [prwm_pkg::SLOT_W-1:0]       rsp_slot,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [prwm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [prwm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [prwm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import prwm_pkg::*;

   localparam int PTR_W  = $clog2(RING_SLOTS);
   localparam int SEXT_W = (PTR_W > SLOT_W) ? PTR_W : SLOT_W;

   // Configuration registers
   logic [WINDOW_W-1:0] window_ticks_ff;
   logic [SCALE_W-1:0]  rate_scale_ff;
   logic [THRESH_W-1:0] threshold_ff;
   logic                csr_write;
   logic [1:0]          csr_index;

   // Sequencer
   state_type state_ff, state_in;
   logic      accept;
   logic      closing;
   logic      prev_zero;
   logic      finish_go;
   logic      div_start;

   // Window counters
   logic                edge_armed_ff, edge_armed_in;
   logic [BEATS_W-1:0]  beat_count_ff, beat_count_in;
   logic [WINDOW_W-1:0] ticks_ff,      ticks_in;
   logic [BEATS_W-1:0]  beats_now;
   logic [WINDOW_W-1:0] ticks_now;

   // Ring and pointer
   logic [RATE_W-1:0]   ring_ff [RING_SLOTS];
   logic [RING_SLOTS-1:0] ring_valid_ff;
   logic [PTR_W-1:0]    ptr_ff;
   logic [PTR_W-1:0]    ptr_next;
   logic [RATE_W-1:0]   prev_rate;
   logic [SEXT_W-1:0]   slot_ext;

   // Change arithmetic
   logic [RATE_W-1:0]     bpm_ff;
   logic                  neg_ff;
   logic                  zero_prev_ff;
   logic [DIFF_W-1:0]     diff;
   logic [RATE_W-1:0]     diff_mag;
   logic [DIVIDEND_W-1:0] dividend;
   logic [DIVIDEND_W-1:0] quotient;
   logic                  div_done;
   logic [CHANGE_W-1:0]   change;
   logic                  store;

   // Result register
   logic                       rsp_valid_ff;
   logic [RATE_W-1:0]          rsp_rate_ff;
   logic [CHANGE_W-1:0]        rsp_change_ff;
   logic                       rsp_stored_ff;
   logic [SLOT_W-1:0]          rsp_slot_ff;

   // ---------------------------------------------------------------
   // Configuration port: write on access phase, read by index
   // ---------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ticks_ff <= WINDOW_TICKS_RESET;
         rate_scale_ff   <= RATE_SCALE_RESET;
         threshold_ff    <= THRESHOLD_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_WINDOW_TICKS: window_ticks_ff <= csr_pwdata[WINDOW_W-1:0];
            REG_RATE_SCALE:   rate_scale_ff   <= csr_pwdata[SCALE_W-1:0];
            REG_THRESHOLD:    threshold_ff    <= csr_pwdata[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_WINDOW_TICKS: csr_prdata = CSR_DATA_W'(window_ticks_ff);
         REG_RATE_SCALE:   csr_prdata = CSR_DATA_W'(rate_scale_ff);
         REG_THRESHOLD:    csr_prdata = CSR_DATA_W'(threshold_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Beat and tick counting for the sample being taken
   // ---------------------------------------------------------------
   always_comb begin
      beats_now     = beat_count_ff;
      edge_armed_in = edge_armed_ff;
      if (req_beat_level && !edge_armed_ff) begin
         if (beat_count_ff != MAX_BEATS) begin
            beats_now = beat_count_ff + 1'b1;
         end
         edge_armed_in = 1'b1;
      end else if (!req_beat_level) begin
         edge_armed_in = 1'b0;
      end
      ticks_now = ticks_ff;
      if (req_tick && ticks_ff != MAX_TICKS) begin
         ticks_now = ticks_ff + 1'b1;
      end
      closing = req_tick && (ticks_now >= window_ticks_ff);
      beat_count_in = beats_now;
      ticks_in      = ticks_now;
   end

   assign accept = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_armed_ff <= 1'b0;
         beat_count_ff <= '0;
         ticks_ff      <= '0;
      end else if (accept) begin
         if (closing) begin
            // open the next window
            edge_armed_ff <= 1'b0;
            beat_count_ff <= '0;
            ticks_ff      <= '0;
         end else begin
            edge_armed_ff <= edge_armed_in;
            beat_count_ff <= beat_count_in;
            ticks_ff      <= ticks_in;
         end
      end
   end

   // Scale the closing count to a rate
   always_ff @(posedge clock) begin
      if (accept && closing) begin
         bpm_ff <= RATE_W'(beats_now) * RATE_W'(rate_scale_ff);
      end
   end

   // ---------------------------------------------------------------
   // Ring read and percent change numerator
   // ---------------------------------------------------------------
   assign prev_rate = ring_valid_ff[ptr_ff] ? ring_ff[ptr_ff] : '0;
   assign prev_zero = (prev_rate == '0);
   assign ptr_next  = (ptr_ff == PTR_W'(RING_SLOTS - 1)) ? '0 : ptr_ff + 1'b1;
   assign slot_ext  = SEXT_W'(ptr_next);

   always_comb begin
      diff     = {1'b0, prev_rate} - {1'b0, bpm_ff};
      diff_mag = diff[DIFF_W-1] ? RATE_W'(-diff) : diff[RATE_W-1:0];
      dividend = DIVIDEND_W'(diff_mag) * DIVIDEND_W'(PCT_FACTOR);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FETCH) begin
         neg_ff       <= diff[DIFF_W-1];
         zero_prev_ff <= prev_zero;
      end
   end

   prwm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (prev_rate),
      .quotient (quotient),
      .done     (div_done)
   );

   // Signed change and store decision
   always_comb begin
      if (zero_prev_ff) begin
         change = CHANGE_W'(threshold_ff);
         store  = 1'b1;
      end else begin
         change = neg_ff ? -CHANGE_W'(quotient) : CHANGE_W'(quotient);
         store  = (quotient >= DIVIDEND_W'(threshold_ff));
      end
   end

   // ---------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && closing) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = prev_zero ? ST_FINISH : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (finish_go) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer: outputs
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      finish_go = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_FETCH:  div_start = ~prev_zero;
         ST_DIVIDE: ;
         ST_FINISH: finish_go = ~rsp_valid_ff | rsp_ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------
   // Ring write and slot pointer advance
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_valid_ff <= '0;
         ptr_ff        <= '0;
      end else if (finish_go) begin
         ptr_ff <= ptr_next;
         if (store) begin
            ring_valid_ff[ptr_next] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish_go && store) begin
         ring_ff[ptr_next] <= bpm_ff;
      end
   end

   // ---------------------------------------------------------------
   // Result register: load on finish, hold until taken
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_go) begin
         rsp_rate_ff   <= bpm_ff;
         rsp_change_ff <= change;
         rsp_stored_ff <= store;
         rsp_slot_ff   <= slot_ext[SLOT_W-1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rate_bpm   = rsp_rate_ff;
   assign rsp_change_pct = rsp_change_ff;
   assign rsp_stored     = rsp_stored_ff;
   assign rsp_slot       = rsp_slot_ff;

endmodule
